// ----- src/rip_pkg.sv -----
package rip_pkg;

  localparam int OffsetBits = 16;
  localparam int ValueBits  = 64;
  localparam int RadixBits  = 6;
  localparam int CharBits   = 8;

  localparam logic [OffsetBits-1:0] OffMax = {OffsetBits{1'b1}};

  localparam logic [CharBits-1:0] ChNul   = 8'h00;
  localparam logic [CharBits-1:0] ChSpace = 8'h20;
  localparam logic [CharBits-1:0] ChTab   = 8'h09;
  localparam logic [CharBits-1:0] ChCr    = 8'h0D;
  localparam logic [CharBits-1:0] ChPlus  = 8'h2B;
  localparam logic [CharBits-1:0] ChMinus = 8'h2D;
  localparam logic [CharBits-1:0] ChZero  = 8'h30;
  localparam logic [CharBits-1:0] ChNine  = 8'h39;
  localparam logic [CharBits-1:0] ChUpA   = 8'h41;
  localparam logic [CharBits-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharBits-1:0] ChLoA   = 8'h61;
  localparam logic [CharBits-1:0] ChLoZ   = 8'h7A;
  localparam logic [CharBits-1:0] ChUpX   = 8'h58;
  localparam logic [CharBits-1:0] ChLoX   = 8'h78;

  localparam logic [RadixBits-1:0] NoDigit  = 6'd36;
  localparam logic [RadixBits-1:0] Base8    = 6'd8;
  localparam logic [RadixBits-1:0] Base10   = 6'd10;
  localparam logic [RadixBits-1:0] Base16   = 6'd16;
  localparam logic [RadixBits-1:0] RadixMax = 6'd36;
  localparam logic [RadixBits-1:0] RadixOne = 6'd1;
  localparam logic [RadixBits-1:0] RadixAuto = 6'd0;

  // digit worth: 0-9, then letters 10..35, anything else 36
  function automatic logic [RadixBits-1:0] digit_of(input logic [CharBits-1:0] c);
    logic [CharBits-1:0] t;
    t = '0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      return t[RadixBits-1:0];
    end else if (c >= ChLoA && c <= ChLoZ) begin
      t = c - ChLoA + 8'd10;
      return t[RadixBits-1:0];
    end else if (c >= ChUpA && c <= ChUpZ) begin
      t = c - ChUpA + 8'd10;
      return t[RadixBits-1:0];
    end
    return NoDigit;
  endfunction

  function automatic logic is_blank(input logic [CharBits-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic [OffsetBits-1:0] sat_inc(input logic [OffsetBits-1:0] p);
    return (p == OffMax) ? p : p + 1'b1;
  endfunction

endpackage

// ----- src/radix_integer_parse_core.sv -----
// Streaming string-to-integer parser (strtoul style). Characters arrive one
// beat per cycle on the char channel while char_ready is high and pass
// through a one-entry input register; the parse step (blank skip, sign,
// prefix detection and the 64-bit multiply-add of the accumulator by the
// base) is combinational from that register to the result register. A string
// is consumed at one character per clock while the result register is free;
// a result is registered when the character that ends the number is parsed.
// The limit on rate is the accumulator loop: one 64 x 6 multiply-add per
// character. radix is sampled when the first character after blanks and sign
// is parsed; write it only while no string is in flight.
module radix_integer_parse_core
  import rip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  radix_we,
  input  logic [RadixBits-1:0]  radix,
  input  logic                  char_valid,
  output logic                  char_ready,
  input  logic [CharBits-1:0]   char_code,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [ValueBits-1:0]  value,
  output logic [OffsetBits-1:0] end_offset
);

  typedef enum logic [2:0] {
    PH_SPACE, PH_SIGNED, PH_ZERO, PH_XPREFIX, PH_DIGITS, PH_DROP
  } phase_t;

  logic [RadixBits-1:0]  radix_reg;
  logic                  in_full;
  logic [CharBits-1:0]   in_char;

  phase_t                phase, phase_next;
  logic                  negative, negative_next;
  logic [RadixBits-1:0]  active_base, active_base_next;
  logic [ValueBits-1:0]  accumulator, accumulator_next;
  logic [OffsetBits-1:0] position, position_next;

  logic                  stop;
  logic [ValueBits-1:0]  stop_val;
  logic [OffsetBits-1:0] stop_off;
  logic                  step_fire;

  logic [RadixBits-1:0]  dig;
  logic [ValueBits-1:0]  mac;
  logic [OffsetBits-1:0] pos1;
  logic [RadixBits-1:0]  fix_base;
  logic                  bad_radix;

  assign dig       = digit_of(in_char);
  assign mac       = ValueBits'(accumulator * ValueBits'(active_base)) + ValueBits'(dig);
  assign pos1      = sat_inc(position);
  assign fix_base  = (radix_reg == RadixAuto) ? Base10 : radix_reg;
  assign bad_radix = (radix_reg == RadixOne) || (radix_reg > RadixMax);

  // step may fire when a result it makes has somewhere to go
  assign step_fire  = in_full && (!stop || !result_valid || result_ready);
  assign char_ready = !in_full || step_fire;

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    active_base_next = active_base;
    accumulator_next = accumulator;
    position_next    = position;
    stop             = 1'b0;
    stop_val         = '0;
    stop_off         = '0;

    case (phase)
      PH_SPACE, PH_SIGNED: begin
        if (phase == PH_SPACE && in_char == ChNul) begin
          stop = 1'b1;
        end else if (phase == PH_SPACE && is_blank(in_char)) begin
          position_next = pos1;
        end else if (phase == PH_SPACE && (in_char == ChPlus || in_char == ChMinus)) begin
          negative_next = (in_char == ChMinus);
          phase_next    = PH_SIGNED;
          position_next = pos1;
        end else if (bad_radix) begin
          stop = 1'b1;
        end else if (in_char == ChZero &&
                     (radix_reg == RadixAuto || radix_reg == Base16)) begin
          active_base_next = (radix_reg == RadixAuto) ? Base8 : Base16;
          accumulator_next = '0;
          phase_next       = PH_ZERO;
          position_next    = pos1;
        end else if (dig >= fix_base) begin
          stop = 1'b1;
        end else begin
          active_base_next = fix_base;
          accumulator_next = ValueBits'(dig);
          phase_next       = PH_DIGITS;
          position_next    = pos1;
        end
      end
      PH_ZERO, PH_DIGITS: begin
        if (phase == PH_ZERO && (in_char == ChLoX || in_char == ChUpX)) begin
          // offset stays on the 'x' in case no hex digit follows
          active_base_next = Base16;
          phase_next       = PH_XPREFIX;
        end else if (dig < active_base) begin
          accumulator_next = mac;
          position_next    = pos1;
        end else begin
          stop     = 1'b1;
          stop_val = negative ? ValueBits'(0) - accumulator : accumulator;
          stop_off = position;
        end
      end
      PH_XPREFIX: begin
        if (dig >= Base16) begin
          stop     = 1'b1;
          stop_off = position;
        end else begin
          accumulator_next = mac;
          position_next    = sat_inc(pos1);
          phase_next       = PH_DIGITS;
        end
      end
      PH_DROP: begin
        // wait for the NUL
      end
      default: begin
        phase_next = PH_DROP;
      end
    endcase

    if (stop) phase_next = PH_DROP;
    if ((stop || phase == PH_DROP) && in_char == ChNul) begin
      phase_next       = PH_SPACE;
      negative_next    = 1'b0;
      active_base_next = '0;
      accumulator_next = '0;
      position_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg    <= RadixAuto;
      in_full      <= 1'b0;
      result_valid <= 1'b0;
      phase        <= PH_SPACE;
      negative     <= 1'b0;
      active_base  <= '0;
      accumulator  <= '0;
      position     <= '0;
    end else begin
      if (radix_we) radix_reg <= radix;

      if (char_valid && char_ready) begin
        in_full <= 1'b1;
        in_char <= char_code;
      end else if (step_fire) begin
        in_full <= 1'b0;
      end

      if (step_fire && stop) begin
        result_valid <= 1'b1;
        value        <= stop_val;
        end_offset   <= stop_off;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (step_fire) begin
        phase       <= phase_next;
        negative    <= negative_next;
        active_base <= active_base_next;
        accumulator <= accumulator_next;
        position    <= position_next;
      end
    end
  end

endmodule

// ----- src/rip_checker.sv -----
module rip_checker
  import rip_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  char_ready,
  input logic                  result_valid,
  input logic                  result_ready,
  input logic [ValueBits-1:0]  value,
  input logic [OffsetBits-1:0] end_offset
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(value) && $stable(end_offset))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

  // with the result slot free the parser never stalls input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> char_ready)
    else $error("input stalled with empty result register");

  // no digit consumed means nothing to report
  a_zero_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && end_offset == '0 |-> value == '0)
    else $error("non-zero value with zero end offset");

endmodule

bind radix_integer_parse_core rip_checker u_rip_checker (
  .clk          (clk),
  .rst          (rst),
  .char_ready   (char_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .value        (value),
  .end_offset   (end_offset)
);
